// ----- rtl/bust_pkg.sv -----
// Package for the bounded unordered set table: request and response beat types
// and the request codes. It has no dependencies.
`default_nettype none

package bust_pkg;

    // Request codes
    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_CONTAINS = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_LIST     = 3'd4;

    // One request beat
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] item_value;
    } req_t;

    // One response beat
    typedef struct packed {
        logic        ok;
        logic [4:0]  size_now;
        logic        is_empty;
        logic [31:0] listed_value;
        logic        last;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/bounded_unordered_set_table_unit.sv -----
// Top level of the bounded unordered set table: sequencer around one value RAM.
// Depends on bust_pkg and bust_ram.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------
//  request | req_valid | req_stall | req (bust_pkg::req_t)
//  response| rsp_valid | rsp_stall | rsp (bust_pkg::rsp_t)
//
// Add, remove and contains scan the stored entries one per cycle through the
// RAM read port; a remove that hits then moves the last entry into the hole.
// Clear and unknown codes give one beat; list, one beat a cycle unless stalled.
// Reset clears state, count and response; RAM is never read before written.
// A new request is taken once the previous one has handed its last beat to the
// response register; response stalls hold the sequencer where a beat waits.
`default_nettype none

module bounded_unordered_set_table_unit #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bust_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bust_pkg::rsp_t rsp
);

    import bust_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOVE,
        ST_LIST,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [VW-1:0]   key_reg, key_next;
    logic [2:0]      op_reg, op_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]   fidx_reg, fidx_next;
    logic            ok_reg, ok_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_data_reg, out_data_next;

    // RAM port signals
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [VW-1:0]   ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [VW-1:0]   ram_rdata;

    logic [63:0]     item_ext;
    logic [63:0]     rd_ext;
    logic [15:0]     cnt_ext;
    logic [CW-1:0]   last_pos;
    logic [VW-1:0]   key_in;
    logic            hit;
    logic            out_free;
    logic            list_last;
    logic            accept;

    bust_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Field width adaptation
    assign item_ext  = 64'(req.item_value);
    assign key_in    = item_ext[VW-1:0];
    assign rd_ext    = 64'(ram_rdata);
    assign cnt_ext   = 16'(count_reg);
    assign last_pos  = CW'(count_reg - CW'(1));

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign hit       = pend_reg && (ram_rdata == key_reg);
    assign list_last = ((CW'(cmp_idx_reg) + CW'(1)) == count_reg);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        op_next       = op_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        cmp_idx_next  = cmp_idx_reg;
        fidx_next     = fidx_reg;
        ok_next       = ok_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[AW-1:0];
        ram_wdata     = key_reg;
        ram_re        = 1'b0;
        ram_raddr     = rd_idx_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next     = key_in;
                    op_next      = req.req_type;
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    cmp_idx_next = '0;
                    case (req.req_type)
                        OP_ADD, OP_REMOVE, OP_CONTAINS:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                            state_next = ST_EMIT;
                        end
                        OP_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                ok_next    = 1'b0;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = ST_LIST;
                            end
                        end
                        default:
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            // One read issued and one entry compared per cycle
            ST_SCAN:
            begin
                if (!hit && (rd_idx_reg < count_reg))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_idx_reg[AW-1:0];
                    pend_next    = 1'b1;
                    cmp_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next  = CW'(rd_idx_reg + CW'(1));
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_EMIT;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (!hit && (count_reg < CW'(CAPACITY)))
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = key_reg;
                                count_next = CW'(count_reg + CW'(1));
                                ok_next    = 1'b1;
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (hit)
                            begin
                                // fetch the last entry to fill the hole
                                ram_re     = 1'b1;
                                ram_raddr  = last_pos[AW-1:0];
                                fidx_next  = cmp_idx_reg;
                                state_next = ST_MOVE;
                            end
                            else
                            begin
                                ok_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            ok_next = hit;
                        end
                    endcase
                end
            end

            // Swap-remove: last entry overwrites the removed slot
            ST_MOVE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fidx_reg;
                ram_wdata  = ram_rdata;
                count_next = CW'(count_reg - CW'(1));
                ok_next    = 1'b1;
                state_next = ST_EMIT;
            end

            // One listed beat per cycle unless the response stalls; next read overlaps the load
            ST_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.ok           = 1'b1;
                    out_data_next.size_now     = cnt_ext[4:0];
                    out_data_next.is_empty     = (count_reg == '0);
                    out_data_next.listed_value = rd_ext[31:0];
                    out_data_next.last         = list_last;
                    if (list_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = AW'(cmp_idx_reg + AW'(1));
                        cmp_idx_next = AW'(cmp_idx_reg + AW'(1));
                    end
                end
            end

            // Single-beat result
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.ok           = ok_reg;
                    out_data_next.size_now     = cnt_ext[4:0];
                    out_data_next.is_empty     = (count_reg == '0);
                    out_data_next.listed_value = '0;
                    out_data_next.last         = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        op_reg       <= op_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        fidx_reg     <= fidx_next;
        ok_reg       <= ok_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/bust_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// It has no dependencies.
`default_nettype none

module bust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds when re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
